FILE: hw/rtl/periodic_deadline_scheduler_top_assert.svh
// assertion macros used by the port checker in hw/rtl/pds_checker.sv
`ifndef PERIODIC_DEADLINE_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_DEADLINE_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define PDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/pds_pkg.sv
package pds_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int US_PER_MS = 1000;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_POLL   = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NONE  = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_ZERO  = 2'd3;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] per;
      logic [63:0] dl;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INS,
      OP_DEL,
      OP_MOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [63:0] key_dl;
      logic [31:0] key_id;
      entry_type   ent;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_MOVE
   } state_type;

endpackage

FILE: hw/rtl/pds_cell.sv
module pds_cell (
   input  logic                  clock,
   input  pds_pkg::cell_cmd_type cmd,
   input  logic                  first,
   input  logic                  vld,
   input  pds_pkg::entry_type    left_ent,
   input  logic                  left_flag,
   input  pds_pkg::entry_type    right_ent,
   input  logic                  right_flag,
   input  logic                  seen_in,
   output pds_pkg::entry_type    ent,
   output logic                  flag,
   output logic                  seen_out
);
   import pds_pkg::*;

   entry_type ent_ff, ent_in;

   always_comb begin
      case (cmd.op)
         OP_INS:  flag = vld && (ent_ff.dl <= cmd.key_dl);
         OP_DEL:  flag = vld && (ent_ff.id == cmd.key_id);
         OP_MOVE: flag = vld && !first && (ent_ff.dl < cmd.key_dl);
         default: flag = 1'b0;
      endcase
   end

   assign seen_out = seen_in | flag;

   always_comb begin
      ent_in = ent_ff;
      case (cmd.op)
         OP_INS: begin
            if (!flag) begin
               if (first || left_flag) ent_in = cmd.ent;
               else ent_in = left_ent;
            end
         end
         OP_DEL: begin
            if (seen_in || flag) ent_in = right_ent;
         end
         OP_MOVE: begin
            // entries ahead of the new deadline slide toward the head
            if (right_flag) ent_in = right_ent;
            else if (first || flag) ent_in = cmd.ent;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

FILE: hw/rtl/pds_rem.sv
module pds_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] rem
);
   import pds_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   assign trial = {rem_ff, quo_ff[63]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one restoring step per cycle, msb first
         quo_in = {quo_ff[62:0], 1'b0};
         if (trial >= {1'b0, div_ff}) rem_in = 32'(trial - {1'b0, div_ff});
         else rem_in = trial[31:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: hw/rtl/periodic_deadline_scheduler_top.sv
// one item at a time: accept, then ST_EXEC, which waits for a free result slot; result is registered
// a due poll goes through ST_MOVE to reinsert its entry
// a due poll that has fallen behind its deadline runs the 64-step remainder unit (ST_DIV) first
// a new item is taken only back in ST_IDLE, after the last one is done; rsp stalls hold it up
// table updates are applied across the whole row of cells together and registered in the cells
// synchronous reset empties the table and drops any pending result
module periodic_deadline_scheduler_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [119:0]  req_tdata,  // session_id[31:0], period_ms[54:32], now_us[118:55]
   input  logic [1:0]    req_tuser,  // kind[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,  // due_session[31:0]
   output logic [1:0]    rsp_tuser   // status[1:0]
);
   import pds_pkg::*;

   localparam int N = TABLE_ENTRIES;

   state_type   state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] sid_ff, sid_in;
   logic [22:0] pms_ff, pms_in;
   logic [63:0] now_ff, now_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_sid_ff, rsp_sid_in;
   entry_type   head_ff, head_in;
   logic [63:0] newdl_ff, newdl_in;

   cell_cmd_type cmd;
   entry_type    ents [N];
   logic [N-1:0] flags, seens, vlds;

   logic        accept, out_free;
   logic [32:0] prod;
   logic [31:0] pus;
   logic [64:0] add_sum, per_sum, fix_sum;
   logic [63:0] add_dl, diff;
   logic        due, div_start, div_done;
   logic [31:0] div_rem, delta;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign prod    = 33'(pms_ff) * 33'(US_PER_MS);
   assign pus     = prod[32] ? 32'hFFFF_FFFF : prod[31:0];
   assign add_sum = {1'b0, now_ff} + {33'd0, pus};
   assign add_dl  = add_sum[64] ? {64{1'b1}} : add_sum[63:0];

   assign due     = (count_ff != '0) && (ents[0].dl <= now_ff);
   assign diff    = now_ff - ents[0].dl;
   assign per_sum = {1'b0, ents[0].dl} + {33'd0, ents[0].per};
   assign delta   = (div_rem == '0) ? 32'd0 : head_ff.per - div_rem;
   assign fix_sum = {1'b0, now_ff} + {33'd0, delta};

   assign div_start = (state_ff == ST_EXEC) && (kind_ff == KIND_POLL) && due &&
                      (ents[0].per != '0) && (diff != '0);

   pds_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff),
      .divisor  (ents[0].per),
      .done     (div_done),
      .rem      (div_rem)
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      entry_type left_e, right_e;
      logic      left_f, right_f, seen_i;

      assign vlds[i] = IDX < count_ff;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_f = 1'b0;
         assign seen_i = 1'b0;
      end else begin : g_mid
         assign left_e = ents[i-1];
         assign left_f = flags[i-1];
         assign seen_i = seens[i-1];
      end
      if (i == N - 1) begin : g_last
         assign right_e = '0;
         assign right_f = 1'b0;
      end else begin : g_rest
         assign right_e = ents[i+1];
         assign right_f = flags[i+1];
      end

      pds_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .first      (i == 0),
         .vld        (vlds[i]),
         .left_ent   (left_e),
         .left_flag  (left_f),
         .right_ent  (right_e),
         .right_flag (right_f),
         .seen_in    (seen_i),
         .ent        (ents[i]),
         .flag       (flags[i]),
         .seen_out   (seens[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (kind_ff == KIND_POLL && due) begin
               if (div_start) state_in = ST_DIV;
               else state_in = ST_MOVE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV:  if (div_done) state_in = ST_MOVE;
         ST_MOVE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in       = kind_ff;
      sid_in        = sid_ff;
      pms_in        = pms_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      newdl_in      = newdl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_sid_in    = rsp_sid_ff;
      cmd           = '0;
      cmd.op        = OP_HOLD;
      req_tready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_tuser;
               sid_in  = req_tdata[31:0];
               pms_in  = req_tdata[54:32];
               now_in  = req_tdata[118:55];
            end
         end
         ST_EXEC: begin
            if (kind_ff == KIND_POLL && due) begin
               head_in = ents[0];
               if (ents[0].per == '0) newdl_in = ents[0].dl;
               else newdl_in = per_sum[64] ? {64{1'b1}} : per_sum[63:0];
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sid_in    = '0;
               rsp_status_in = STAT_NONE;
               case (kind_ff)
                  KIND_ADD: begin
                     if (pms_ff == '0) begin
                        rsp_status_in = STAT_ZERO;
                     end else if (count_ff == CNT_W'(N)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cmd.op     = OP_INS;
                        cmd.key_dl = add_dl;
                        cmd.ent    = '{id: sid_ff, per: pus, dl: add_dl};
                        count_in   = count_ff + CNT_W'(1);
                        rsp_status_in = STAT_OK;
                     end
                  end
                  KIND_REMOVE: begin
                     cmd.op     = OP_DEL;
                     cmd.key_id = sid_ff;
                     if (seens[N-1]) begin
                        count_in      = count_ff - CNT_W'(1);
                        rsp_status_in = STAT_OK;
                     end
                  end
                  default: rsp_status_in = STAT_NONE;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) newdl_in = fix_sum[64] ? {64{1'b1}} : fix_sum[63:0];
         end
         ST_MOVE: begin
            if (out_free) begin
               cmd.op        = OP_MOVE;
               cmd.key_dl    = newdl_ff;
               cmd.ent       = '{id: head_ff.id, per: head_ff.per, dl: newdl_ff};
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_sid_in    = head_ff.id;
            end
         end
         default: cmd.op = OP_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      sid_ff        <= sid_in;
      pms_ff        <= pms_in;
      now_ff        <= now_in;
      head_ff       <= head_in;
      newdl_ff      <= newdl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sid_ff    <= rsp_sid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sid_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: hw/rtl/pds_checker.sv
`include "periodic_deadline_scheduler_top_assert.svh"

module pds_port_assert (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);
   import pds_pkg::*;

   // stalled result beat holds
   `PDS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one item in flight: no accept right after an accept
   `PDS_ASSERT_NXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   // a beat whose status is not OK carries a zero session id
   `PDS_ASSERT_IMP(a_sid_zero, clock, reset, rsp_tvalid && (rsp_tuser != STAT_OK), rsp_tdata == '0)
   // reset drops any pending result
   `PDS_ASSERT_NXT(a_reset_out, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind periodic_deadline_scheduler_top pds_port_assert u_pds_port_assert (.*);

FILE: dv/pds_checker.sv
`timescale 1ns / 1ps

module pds_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [119:0]  req_tdata,
   input  logic [1:0]    req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [31:0]   rsp_tdata,
   input  logic [1:0]    rsp_tuser,
   output int            fail_count,
   output int            pending,
   output int            polls_due,
   output int            adds_done
);
   import pds_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] sid;
   } answer_type;

   logic [31:0] tbl_id [TABLE_ENTRIES];
   logic [31:0] tbl_per [TABLE_ENTRIES];
   logic [63:0] tbl_dl [TABLE_ENTRIES];
   int          tbl_cnt;
   answer_type  answers_q[$];

   assign pending = answers_q.size();

   function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

   function automatic answer_type schedule_step(logic [1:0] kind, logic [31:0] sid,
                                                logic [22:0] pms, logic [63:0] now);
      answer_type  a;
      logic [63:0] pus64, dl, p, diff, steps, head;
      logic [31:0] pus, id;
      int          pos;
      a = '{status: STAT_NONE, sid: 32'd0};
      case (kind)
         KIND_ADD: begin
            if (pms == 0) begin
               a.status = STAT_ZERO;
            end else if (tbl_cnt >= TABLE_ENTRIES) begin
               a.status = STAT_FULL;
            end else begin
               pus64 = 64'(pms) * US_PER_MS;
               pus = (pus64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pus64[31:0];
               dl = sat_sum(now, 64'(pus));
               pos = 0;
               while (pos < tbl_cnt && tbl_dl[pos] <= dl) pos++;
               for (int k = tbl_cnt; k > pos; k--) begin
                  tbl_id[k] = tbl_id[k-1];
                  tbl_per[k] = tbl_per[k-1];
                  tbl_dl[k] = tbl_dl[k-1];
               end
               tbl_id[pos] = sid;
               tbl_per[pos] = pus;
               tbl_dl[pos] = dl;
               tbl_cnt++;
               a.status = STAT_OK;
            end
         end
         KIND_REMOVE: begin
            pos = 0;
            while (pos < tbl_cnt && tbl_id[pos] != sid) pos++;
            if (pos < tbl_cnt) begin
               for (int k = pos; k + 1 < tbl_cnt; k++) begin
                  tbl_id[k] = tbl_id[k+1];
                  tbl_per[k] = tbl_per[k+1];
                  tbl_dl[k] = tbl_dl[k+1];
               end
               tbl_cnt--;
               a.status = STAT_OK;
            end
         end
         KIND_POLL: begin
            if (tbl_cnt > 0 && tbl_dl[0] <= now) begin
               id = tbl_id[0];
               pus = tbl_per[0];
               dl = tbl_dl[0];
               p = 64'(pus);
               a = '{status: STAT_OK, sid: id};
               if (p != 0) begin
                  diff = now - dl;
                  steps = diff / p + ((diff % p) != 0 ? 64'd1 : 64'd0);
                  if (steps == 0) steps = 1;
                  head = 64'hFFFF_FFFF_FFFF_FFFF - dl;
                  if (steps > head / p) dl = 64'hFFFF_FFFF_FFFF_FFFF;
                  else dl = dl + steps * p;
               end
               // entry slides back ahead of equal deadlines
               pos = 0;
               while (pos + 1 < tbl_cnt && tbl_dl[pos+1] < dl) begin
                  tbl_id[pos] = tbl_id[pos+1];
                  tbl_per[pos] = tbl_per[pos+1];
                  tbl_dl[pos] = tbl_dl[pos+1];
                  pos++;
               end
               tbl_id[pos] = id;
               tbl_per[pos] = pus;
               tbl_dl[pos] = dl;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         tbl_cnt = 0;
         answers_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_q.size() == 0) begin
               report("unexpected beat", rsp_tdata, 32'd0);
            end else begin
               a = answers_q.pop_front();
               if (rsp_tuser !== a.status) report("status", 32'(rsp_tuser), 32'(a.status));
               if (rsp_tdata !== a.sid) report("due_session", rsp_tdata, a.sid);
            end
         end
         if (req_tvalid && req_tready) begin
            a = schedule_step(req_tuser, req_tdata[31:0], req_tdata[54:32],
                              req_tdata[118:55]);
            if (req_tuser == KIND_POLL && a.status == STAT_OK) polls_due++;
            if (req_tuser == KIND_ADD && a.status == STAT_OK) adds_done++;
            answers_q.push_back(a);
         end
      end
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pds_pkg::*;

   localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int CYCLE_LIMIT = 1500000;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [119:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   int            fail_count, pending, polls_due, adds_done;
   int            cycles = 0;
   int            sent = 0;
   logic [63:0]   clock_us = 64'd0;
   logic [31:0]   live_ids [$];

   always #5 clock = ~clock;

   periodic_deadline_scheduler_top DUT (.*);

   pds_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver inserts a random stall before each beat; one draw in four forces no stall
   initial begin
      int w;
      forever begin
         w = $urandom_range(0, 16);
         if ($urandom_range(0, 3) == 0) w = 0;
         repeat (w) @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_tready <= 1'b0;
      end
   end

   // valid stays up across back-to-back beats and drops only for a gap
   task automatic send_beat(logic [1:0] kind, logic [31:0] sid, logic [22:0] pms,
                            logic [63:0] now, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, now, pms, sid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   function automatic int pick_gap(int bool_burst);
      return bool_burst ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic random_beat(int burst);
      int          r;
      logic [31:0] sid;
      logic [22:0] pms;
      r = $urandom_range(0, 99);
      clock_us = clock_us + $urandom_range(0, 40000);
      if (r < 30) begin
         sid = $urandom_range(0, 7) == 0 ? $urandom() : 32'($urandom_range(0, 20));
         pms = $urandom_range(0, 19) == 0 ? 23'($urandom()) : 23'($urandom_range(0, 50));
         send_beat(KIND_ADD, sid, pms, clock_us, pick_gap(burst));
         if (pms != 0) live_ids.push_back(sid);
      end else if (r < 45) begin
         if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
            sid = live_ids[$urandom_range(0, live_ids.size() - 1)];
         else
            sid = $urandom();
         send_beat(KIND_REMOVE, sid, 23'($urandom()), 64'({$urandom(), $urandom()}),
                   pick_gap(burst));
      end else if (r < 97) begin
         // occasionally jump time far ahead to force catch-up
         if ($urandom_range(0, 30) == 0) clock_us = clock_us + $urandom_range(0, 9000000);
         send_beat(KIND_POLL, $urandom(), 23'($urandom()), clock_us, pick_gap(burst));
      end else begin
         send_beat(KIND_SPARE, $urandom(), 23'($urandom()), 64'({$urandom(), $urandom()}),
                   pick_gap(burst));
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, zero period, extremes, overflow, full table
      send_beat(KIND_POLL, 32'd0, 23'd0, 64'd0, 0);
      send_beat(KIND_REMOVE, 32'hFFFF_FFFF, 23'd0, 64'd0, 0);
      send_beat(KIND_ADD, 32'd5, 23'd0, 64'd0, 0);
      send_beat(KIND_SPARE, 32'hFFFF_FFFF, 23'h7F_FFFF, T_MAX, 0);
      send_beat(KIND_ADD, 32'hFFFF_FFFF, 23'h7F_FFFF, T_MAX - 64'd10, 1);
      send_beat(KIND_ADD, 32'd1, 23'd1, 64'd0, 0);
      send_beat(KIND_ADD, 32'd2, 23'd1, 64'd0, 0);
      send_beat(KIND_ADD, 32'd3, 23'd4294967, 64'd100, 2);
      send_beat(KIND_POLL, 32'd0, 23'd0, 64'd999, 0);
      send_beat(KIND_POLL, 32'd0, 23'd0, 64'd1000, 0);
      send_beat(KIND_POLL, 32'd0, 23'd0, 64'd1000, 0);
      send_beat(KIND_POLL, 32'd0, 23'd0, 64'd5_000_500, 3);
      send_beat(KIND_REMOVE, 32'd2, 23'd0, 64'd0, 0);
      send_beat(KIND_REMOVE, 32'd2, 23'd0, 64'd0, 0);
      for (int i = 0; i < 14; i++)
         send_beat(KIND_ADD, 32'(100 + i), 23'(i + 1), 64'd10_000_000, 0);
      send_beat(KIND_ADD, 32'd99, 23'd7, 64'd0, 0);
      send_beat(KIND_POLL, 32'd0, 23'd0, T_MAX, 0);
      send_beat(KIND_POLL, 32'd0, 23'd0, T_MAX, 0);
      drain();

      // empty the table between phases
      for (int i = 0; i < 14; i++) send_beat(KIND_REMOVE, 32'(100 + i), 23'd0, 64'd0, 0);
      for (int i = 1; i < 4; i++) send_beat(KIND_REMOVE, 32'(i), 23'd0, 64'd0, 0);
      send_beat(KIND_REMOVE, 32'hFFFF_FFFF, 23'd0, 64'd0, 0);
      drain();

      for (int n = 0; n < 1300; n++) begin
         random_beat((n / 100) % 3 == 1);
         if (n == 650) drain();
      end

      drain();
      $display("sent %0d items: %0d subscriptions added, %0d due polls answered",
               sent, adds_done, polls_due);
      $display("covered zero period, full table, missing ids, saturation and catch-up");
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
